/* hdl/scaled_scanout_format_converter_macros.svh */
// Assertion macros shared by the checker.
`ifndef SCALED_SCANOUT_FORMAT_CONVERTER_MACROS_SVH
`define SCALED_SCANOUT_FORMAT_CONVERTER_MACROS_SVH

// same-cycle implication
`define SSFC_ASSERT_NOW(label, clk, dis, a, b) \
  label: assert property (@(posedge clk) disable iff (dis) (a) |-> (b)) \
    else $error("ssfc assertion failed");

// next-cycle implication
`define SSFC_ASSERT_NEXT(label, clk, dis, a, b) \
  label: assert property (@(posedge clk) disable iff (dis) (a) |=> (b)) \
    else $error("ssfc assertion failed");

`endif

/* hdl/ssfc_pkg.sv */
package ssfc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_DIM_DEF   = 4096;

  localparam int ACC_W   = 28;
  localparam int COORD_W = 12;
  localparam int ORG_W   = 11;
  localparam int STEP_W  = 27;
  localparam int DIM_W   = 13;
  localparam int CFG_W   = 27;
  localparam int IDX_W   = 3;
  localparam int SRC_W   = 32;
  localparam int PIX_W   = 24;

  typedef enum logic [IDX_W-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_STEP_X      = 3'd2,
    REG_STEP_Y      = 3'd3,
    REG_OUT_WIDTH   = 3'd4,
    REG_OUT_HEIGHT  = 3'd5,
    REG_SRC_FORMAT  = 3'd6,
    REG_DEST_FORMAT = 3'd7
  } reg_idx_t;

  typedef enum logic {
    SRC_ABGR32  = 1'b0,
    SRC_ABGR16  = 1'b1
  } src_fmt_t;

  typedef enum logic [1:0] {
    DST_RGB555 = 2'd0,
    DST_RGB565 = 2'd1,
    DST_RGB888 = 2'd2
  } dst_fmt_t;

  typedef struct packed {
    logic [ORG_W-1:0]  origin_x;
    logic [ORG_W-1:0]  origin_y;
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_y;
    logic [DIM_W-1:0]  out_width;
    logic [DIM_W-1:0]  out_height;
    src_fmt_t          source_format;
    dst_fmt_t          dest_format;
  } cfg_t;

  typedef struct packed {
    logic               line_end;
    logic               frame_end;
    logic [COORD_W-1:0] fetch_x;
    logic [COORD_W-1:0] fetch_y;
  } walk_t;

endpackage

/* hdl/ssfc_regs.sv */
module ssfc_regs
  import ssfc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg,
  output logic             origin_write
);

  assign origin_write = cfg_we &&
    (reg_idx_t'(cfg_index) == REG_ORIGIN_X || reg_idx_t'(cfg_index) == REG_ORIGIN_Y);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x      <= '0;
      cfg.origin_y      <= '0;
      cfg.step_x        <= STEP_W'(65536);
      cfg.step_y        <= STEP_W'(65536);
      cfg.out_width     <= DIM_W'(640);
      cfg.out_height    <= DIM_W'(480);
      cfg.source_format <= SRC_ABGR32;
      cfg.dest_format   <= DST_RGB888;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ORIGIN_X:    cfg.origin_x      <= cfg_data[ORG_W-1:0];
        REG_ORIGIN_Y:    cfg.origin_y      <= cfg_data[ORG_W-1:0];
        REG_STEP_X:      cfg.step_x        <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:      cfg.step_y        <= cfg_data[STEP_W-1:0];
        REG_OUT_WIDTH:   cfg.out_width     <= cfg_data[DIM_W-1:0];
        REG_OUT_HEIGHT:  cfg.out_height    <= cfg_data[DIM_W-1:0];
        REG_SRC_FORMAT:  cfg.source_format <= src_fmt_t'(cfg_data[0]);
        REG_DEST_FORMAT: cfg.dest_format   <= dst_fmt_t'(cfg_data[1:0]);
      endcase
    end
  end

endmodule

/* hdl/ssfc_convert.sv */
module ssfc_convert
  import ssfc_pkg::*;
(
  input  cfg_t             cfg,
  input  logic [SRC_W-1:0] src,
  output logic [PIX_W-1:0] pix
);

  always_comb begin
    if (cfg.source_format == SRC_ABGR32) begin
      unique case (cfg.dest_format)
        DST_RGB555: pix = {9'd0, src[7:3], src[15:11], src[23:19]};
        DST_RGB565: pix = {8'd0, src[7:3], src[15:10], src[23:19]};
        DST_RGB888: pix = {src[7:0], src[15:8], src[23:16]};
        default:    pix = {src[7:0], src[15:8], src[23:16]};
      endcase
    end else begin
      unique case (cfg.dest_format)
        DST_RGB555: pix = {9'd0, src[4:0], src[9:5], src[14:10]};
        DST_RGB565: pix = {8'd0, src[4:0], src[9:5], 1'b0, src[14:10]};
        DST_RGB888: pix = {src[4:0], 3'd0, src[9:5], 3'd0, src[14:10], 3'd0};
        default:    pix = {src[4:0], 3'd0, src[9:5], 3'd0, src[14:10], 3'd0};
      endcase
    end
  end

endmodule

/* hdl/ssfc_walker.sv */
module ssfc_walker
  import ssfc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_DIM   = MAX_DIM_DEF
)(
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  origin_write,
  input  logic  advance,
  output walk_t walk
);

  // MAX_DIM is a power of two
  localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'(MAX_DIM - 1);
  localparam logic [DIM_W-1:0]   DIM_MAX    = DIM_W'(MAX_DIM);

  logic [COORD_W-1:0] column, column_next;
  logic [COORD_W-1:0] row, row_next;
  logic [ACC_W-1:0]   pos_x, pos_x_next;
  logic [ACC_W-1:0]   pos_y, pos_y_next;
  logic               reload;
  logic [ACC_W-1:0]   org_x_acc, org_y_acc;
  logic [DIM_W-1:0]   eff_w, eff_h;
  logic               lend, fend;
  logic [ACC_W-1:0]   int_x, int_y;

  assign org_x_acc = ACC_W'({cfg.origin_x, {FRAC_BITS{1'b0}}});
  assign org_y_acc = ACC_W'({cfg.origin_y, {FRAC_BITS{1'b0}}});

  always_comb begin
    priority if (cfg.out_width == '0) eff_w = DIM_W'(1);
    else if (cfg.out_width > DIM_MAX) eff_w = DIM_MAX;
    else                              eff_w = cfg.out_width;
    priority if (cfg.out_height == '0) eff_h = DIM_W'(1);
    else if (cfg.out_height > DIM_MAX) eff_h = DIM_MAX;
    else                               eff_h = cfg.out_height;
  end

  assign lend = ({1'b0, column} + DIM_W'(1)) >= eff_w;
  assign fend = lend && (({1'b0, row} + DIM_W'(1)) >= eff_h);

  always_comb begin
    column_next = column + COORD_W'(1);
    row_next    = row;
    pos_x_next  = pos_x + ACC_W'(cfg.step_x);
    pos_y_next  = pos_y;
    if (lend) begin
      column_next = '0;
      pos_x_next  = org_x_acc;
      if (fend) begin
        row_next   = '0;
        pos_y_next = org_y_acc;
      end else begin
        row_next   = row + COORD_W'(1);
        pos_y_next = pos_y + ACC_W'(cfg.step_y);
      end
    end
  end

  assign int_x = pos_x_next >> FRAC_BITS;
  assign int_y = pos_y_next >> FRAC_BITS;

  assign walk.line_end  = lend;
  assign walk.frame_end = fend;
  assign walk.fetch_x   = int_x[COORD_W-1:0] & COORD_MASK;
  assign walk.fetch_y   = int_y[COORD_W-1:0] & COORD_MASK;

  // origin writes at frame start set reload, which loads the accumulators in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
      pos_x  <= '0;
      pos_y  <= '0;
      reload <= 1'b0;
    end else begin
      reload <= origin_write && column == '0 && row == '0;
      if (reload) begin
        pos_x <= org_x_acc;
        pos_y <= org_y_acc;
      end else if (advance) begin
        column <= column_next;
        row    <= row_next;
        pos_x  <= pos_x_next;
        pos_y  <= pos_y_next;
      end
    end
  end

endmodule

/* hdl/scaled_scanout_format_converter.sv */
// Each accepted source word passes an input register and then a result register,
// with the accumulator add and pixel shuffle between them. Throughput: one word
// per cycle while res_stall does not hold the result register.
// Reset (rst, synchronous): both stages empty, row/column zero, accumulators
// at the origin, registers at defaults (640x480, unit steps, ABGR32 to 24-bit).
module scaled_scanout_format_converter
  import ssfc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_DIM   = MAX_DIM_DEF
)(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               src_valid,
  output logic               src_stall,
  input  logic [SRC_W-1:0]   src_pixel,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [PIX_W-1:0]   out_pixel,
  output logic               line_end,
  output logic               frame_end,
  output logic [COORD_W-1:0] fetch_x,
  output logic [COORD_W-1:0] fetch_y
);

  cfg_t             cfg;
  logic             origin_write;
  walk_t            walk;
  logic             s1_valid;
  logic [SRC_W-1:0] s1_pixel;
  logic             s1_stall;
  logic             advance;
  logic [PIX_W-1:0] pix;

  assign s1_stall  = res_valid && res_stall;
  assign src_stall = s1_valid && s1_stall;
  assign advance   = s1_valid && !s1_stall;

  ssfc_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg),
    .origin_write (origin_write)
  );

  ssfc_walker #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_DIM   (MAX_DIM)
  ) u_walker (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .origin_write (origin_write),
    .advance      (advance),
    .walk         (walk)
  );

  ssfc_convert u_convert (
    .cfg (cfg),
    .src (s1_pixel),
    .pix (pix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (!src_stall) s1_valid <= src_valid;
      if (!s1_stall)  res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) s1_pixel <= src_pixel;
    if (advance) begin
      out_pixel <= pix;
      line_end  <= walk.line_end;
      frame_end <= walk.frame_end;
      fetch_x   <= walk.fetch_x;
      fetch_y   <= walk.fetch_y;
    end
  end

endmodule

/* hdl/ssfc_checker.sv */
`include "scaled_scanout_format_converter_macros.svh"

module ssfc_checker
  import ssfc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               src_stall,
  input logic               res_valid,
  input logic               res_stall,
  input logic [PIX_W-1:0]   out_pixel,
  input logic               line_end,
  input logic               frame_end,
  input logic [COORD_W-1:0] fetch_x,
  input logic [COORD_W-1:0] fetch_y
);

  `SSFC_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !res_valid)
  `SSFC_ASSERT_NOW(a_stall_only_full, clk, rst, src_stall, res_valid)
  `SSFC_ASSERT_NOW(a_frame_is_line, clk, rst, res_valid && frame_end, line_end)
  `SSFC_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall,
    res_valid && $stable(out_pixel) && $stable(fetch_x) && $stable(fetch_y))

endmodule

bind scaled_scanout_format_converter ssfc_checker u_ssfc_checker (
  .clk       (clk),
  .rst       (rst),
  .src_stall (src_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .out_pixel (out_pixel),
  .line_end  (line_end),
  .frame_end (frame_end),
  .fetch_x   (fetch_x),
  .fetch_y   (fetch_y)
);

/* tb/sv/scaled_scanout_format_converter_test.sv */
`timescale 1ns / 1ps
module scaled_scanout_format_converter_test;
  import ssfc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TOTAL_WORDS = 1650;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES = 120;
  localparam int PRESSURE_AT = 1200;
  localparam logic [1:0] DST_SPARE = 2'd3;
  localparam logic [STEP_W-1:0] STEP_MAX = '1;
  localparam logic [STEP_W-1:0] STEP_UNIT = 27'h10000;
  localparam logic [ORG_W-1:0] ORG_MAX = '1;
  localparam logic [DIM_W-1:0] DIM_MAX = '1;
  localparam logic [DIM_W-1:0] DIM_FULL = 13'd4096;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    walk_t            walk;
  } scan_word_t;

  class scanout_tracker;
    logic [ORG_W-1:0]   origin_x, origin_y;
    logic [STEP_W-1:0]  step_x, step_y;
    logic [DIM_W-1:0]   out_width, out_height;
    src_fmt_t           src_fmt;
    logic [1:0]         dst_fmt;
    logic [COORD_W-1:0] column, row;
    logic [ACC_W-1:0]   acc_x, acc_y;
    scan_word_t         pending_words[$];
    int failures, checked, line_ends, frame_ends;

    function new();
      origin_x = '0;
      origin_y = '0;
      step_x = STEP_UNIT;
      step_y = STEP_UNIT;
      out_width = 13'd640;
      out_height = 13'd480;
      src_fmt = SRC_ABGR32;
      dst_fmt = DST_RGB888;
      column = '0;
      row = '0;
      acc_x = '0;
      acc_y = '0;
      failures = 0;
      checked = 0;
      line_ends = 0;
      frame_ends = 0;
    endfunction

    function logic [ACC_W-1:0] origin_load(logic [ORG_W-1:0] o);
      return ACC_W'({o, {FRAC_BITS_DEF{1'b0}}});
    endfunction

    function int eff_dim(logic [DIM_W-1:0] v);
      if (v == '0) return 1;
      if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
      return int'(v);
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_ORIGIN_X:    origin_x = data[ORG_W-1:0];
        REG_ORIGIN_Y:    origin_y = data[ORG_W-1:0];
        REG_STEP_X:      step_x = data[STEP_W-1:0];
        REG_STEP_Y:      step_y = data[STEP_W-1:0];
        REG_OUT_WIDTH:   out_width = data[DIM_W-1:0];
        REG_OUT_HEIGHT:  out_height = data[DIM_W-1:0];
        REG_SRC_FORMAT:  src_fmt = src_fmt_t'(data[0]);
        REG_DEST_FORMAT: dst_fmt = data[1:0];
        default: ;
      endcase
      // origin reloads only at frame start; otherwise at the next boundary
      if ((idx == REG_ORIGIN_X || idx == REG_ORIGIN_Y) && column == '0 && row == '0) begin
        acc_x = origin_load(origin_x);
        acc_y = origin_load(origin_y);
      end
    endfunction

    function logic [PIX_W-1:0] convert(logic [SRC_W-1:0] w);
      logic [4:0] r5, g5, b5;
      r5 = w[4:0];
      g5 = w[9:5];
      b5 = w[14:10];
      if (src_fmt == SRC_ABGR32) begin
        case (dst_fmt)
          DST_RGB555: return {9'b0, w[7:3], w[15:11], w[23:19]};
          DST_RGB565: return {8'b0, w[7:3], w[15:10], w[23:19]};
          default:    return {w[7:0], w[15:8], w[23:16]};
        endcase
      end
      case (dst_fmt)
        DST_RGB555: return {9'b0, r5, g5, b5};
        DST_RGB565: return {8'b0, r5, g5, 1'b0, b5};
        default:    return {r5, 3'b0, g5, 3'b0, b5, 3'b0};
      endcase
    endfunction

    function void note_source(logic [SRC_W-1:0] w);
      scan_word_t e;
      logic lend, fend;
      e.pixel = convert(w);
      lend = (int'(column) + 1) >= eff_dim(out_width);
      fend = lend && ((int'(row) + 1) >= eff_dim(out_height));
      if (!lend) begin
        column = column + COORD_W'(1);
        acc_x = acc_x + ACC_W'(step_x);
      end else begin
        column = '0;
        acc_x = origin_load(origin_x);
        if (fend) begin
          row = '0;
          acc_y = origin_load(origin_y);
        end else begin
          row = row + COORD_W'(1);
          acc_y = acc_y + ACC_W'(step_y);
        end
      end
      e.walk.line_end = lend;
      e.walk.frame_end = fend;
      e.walk.fetch_x = COORD_W'(acc_x >> FRAC_BITS_DEF);
      e.walk.fetch_y = COORD_W'(acc_y >> FRAC_BITS_DEF);
      pending_words.push_back(e);
    endfunction

    function void flag_mismatch(string name, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      failures++;
    endfunction

    function void check_result(scan_word_t got);
      scan_word_t want;
      if (pending_words.size() == 0) begin
        $display("%0t: result word with none expected, expected none actual %h", $time, got);
        failures++;
        return;
      end
      want = pending_words.pop_front();
      checked++;
      if (want.walk.line_end) line_ends++;
      if (want.walk.frame_end) frame_ends++;
      if (got.pixel !== want.pixel) flag_mismatch("out_pixel", want.pixel, got.pixel);
      if (got.walk.line_end !== want.walk.line_end)
        flag_mismatch("line_end", PIX_W'(want.walk.line_end), PIX_W'(got.walk.line_end));
      if (got.walk.frame_end !== want.walk.frame_end)
        flag_mismatch("frame_end", PIX_W'(want.walk.frame_end), PIX_W'(got.walk.frame_end));
      if (got.walk.fetch_x !== want.walk.fetch_x)
        flag_mismatch("fetch_x", PIX_W'(want.walk.fetch_x), PIX_W'(got.walk.fetch_x));
      if (got.walk.fetch_y !== want.walk.fetch_y)
        flag_mismatch("fetch_y", PIX_W'(want.walk.fetch_y), PIX_W'(got.walk.fetch_y));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               src_valid = 1'b0;
  logic               src_stall;
  logic [SRC_W-1:0]   src_pixel = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic [PIX_W-1:0]   out_pixel;
  logic               line_end;
  logic               frame_end;
  logic [COORD_W-1:0] fetch_x;
  logic [COORD_W-1:0] fetch_y;

  scanout_tracker tracker = new();
  int words_sent = 0;
  int reg_phases = 0;
  int src_idle_pct = 8;
  int res_stall_pct = 53;
  int hold_left = 0;
  bit hold_request = 1'b0;

  scaled_scanout_format_converter i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_pixel (src_pixel),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_pixel (out_pixel),
    .line_end  (line_end),
    .frame_end (frame_end),
    .fetch_x   (fetch_x),
    .fetch_y   (fetch_y)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout with %0d words still expected", $time, tracker.pending_words.size());
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (src_valid && !src_stall) tracker.note_source(src_pixel);
      if (res_valid && !res_stall)
        tracker.check_result({out_pixel, line_end, frame_end, fetch_x, fetch_y});
    end
  end

  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else begin
      res_stall <= ($urandom_range(99) < res_stall_pct);
    end
  end

  task automatic send_word(input logic [SRC_W-1:0] w);
    if (words_sent < TOTAL_WORDS / 3) begin
      src_idle_pct = 8;
      res_stall_pct = 53;
    end else if (words_sent < 2 * TOTAL_WORDS / 3) begin
      src_idle_pct = 53;
      res_stall_pct = 8;
    end else begin
      src_idle_pct = 0;
      res_stall_pct = 0;
    end
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      src_valid <= 1'b0;
      src_pixel <= $urandom;
    end
    @(negedge clk);
    src_valid <= 1'b1;
    src_pixel <= w;
    do @(posedge clk); while (src_stall);
    words_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    src_valid <= 1'b0;
    while (tracker.pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg_port(input reg_idx_t idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    tracker.write_reg(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [ORG_W-1:0] pick_origin();
    case ($urandom_range(3))
      0: return '0;
      1: return ORG_MAX;
      default: return ORG_W'($urandom_range(2047));
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(5))
      0: return '0;
      1: return STEP_MAX;
      2: return STEP_UNIT;
      3: return STEP_W'($urandom);
      default: return STEP_W'($urandom_range(32'h3FFFF));
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(11))
      0: return '0;
      1: return DIM_MAX;
      2: return DIM_FULL;
      3: return DIM_W'($urandom_range(8191));
      default: return DIM_W'($urandom_range(1, 24));
    endcase
  endfunction

  task automatic shuffle_regs();
    if ($urandom_range(1)) write_reg_port(REG_ORIGIN_X, CFG_W'(pick_origin()));
    if ($urandom_range(1)) write_reg_port(REG_ORIGIN_Y, CFG_W'(pick_origin()));
    if ($urandom_range(1)) write_reg_port(REG_STEP_X, pick_step());
    if ($urandom_range(1)) write_reg_port(REG_STEP_Y, pick_step());
    if ($urandom_range(1)) write_reg_port(REG_OUT_WIDTH, CFG_W'(pick_dim()));
    if ($urandom_range(1)) write_reg_port(REG_OUT_HEIGHT, CFG_W'(pick_dim()));
    if ($urandom_range(1)) write_reg_port(REG_SRC_FORMAT, CFG_W'($urandom_range(1)));
    if ($urandom_range(1)) write_reg_port(REG_DEST_FORMAT, CFG_W'($urandom_range(3)));
    reg_phases++;
  endtask

  initial begin
    src_fmt_t   src_codes[2];
    logic [1:0] dst_codes[4];
    int phase_len;
    bit pressure_done;
    src_codes = '{SRC_ABGR32, SRC_ABGR16};
    dst_codes = '{DST_RGB555, DST_RGB565, DST_RGB888, DST_SPARE};
    pressure_done = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'hA5A5_5A5A);
    settle();

    // origin write mid-frame, wrapping steps, zero size acting as one
    write_reg_port(REG_ORIGIN_X, CFG_W'(ORG_MAX));
    write_reg_port(REG_ORIGIN_Y, CFG_W'(ORG_MAX));
    write_reg_port(REG_STEP_X, STEP_MAX);
    write_reg_port(REG_STEP_Y, STEP_MAX);
    write_reg_port(REG_OUT_WIDTH, '0);
    write_reg_port(REG_OUT_HEIGHT, '0);
    send_word(32'h00FF_00FF);
    send_word(32'hFF00_FF00);
    settle();

    // origin write at frame start, oversize width, x accumulator wrap
    write_reg_port(REG_ORIGIN_X, CFG_W'(5));
    write_reg_port(REG_ORIGIN_Y, CFG_W'(1000));
    write_reg_port(REG_OUT_WIDTH, CFG_W'(DIM_MAX));
    write_reg_port(REG_OUT_HEIGHT, CFG_W'(DIM_FULL));
    write_reg_port(REG_STEP_Y, '0);
    foreach (src_codes[s]) begin
      foreach (dst_codes[d]) begin
        write_reg_port(REG_SRC_FORMAT, CFG_W'(src_codes[s]));
        write_reg_port(REG_DEST_FORMAT, CFG_W'(dst_codes[d]));
        send_word(32'h80FF_7C1F);
        send_word(32'h7F00_83E0);
        settle();
      end
    end

    // width shrunk below the current column
    write_reg_port(REG_OUT_WIDTH, CFG_W'(2));
    send_word(32'h1234_5678);
    send_word(32'h8765_4321);
    settle();
    reg_phases += 12;

    while (words_sent < TOTAL_WORDS) begin
      shuffle_regs();
      phase_len = $urandom_range(10, 60);
      if (!pressure_done && words_sent >= PRESSURE_AT) begin
        hold_request = 1'b1;
        pressure_done = 1'b1;
        phase_len = 80;
      end
      repeat (phase_len) send_word($urandom);
      settle();
    end

    $display("Checked %0d result words (%0d line ends, %0d frame ends) over %0d register phases",
             tracker.checked, tracker.line_ends, tracker.frame_ends, reg_phases);
    $display("Both source formats into all dest codes, odd frame sizes, wrapping steps, hold-off");
    if (tracker.failures == 0 && tracker.pending_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
